@@ src/fpdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation: shared package
// Widths, band bounds, the reciprocal used for the divide by three, and the
// types that travel between the front end, the divider cells and the queue.
// ----------------------------------------------------------------------------
package fpdc_pkg;

   // Field widths.
   localparam int CARRIER_W  = 31;
   localparam int CRYSTAL_W  = 25;
   localparam int BAND_W     = 3;
   localparam int DIV_W      = 5;
   localparam int INT_W      = 8;
   localparam int FRAC_W     = 20;
   localparam int FRAC_SHIFT = 19;

   // The phase detector frequency never exceeds crystal / 2.
   localparam int PFD_W     = CRYSTAL_W - 1;
   // Dividend is carrier * 2^19; one divider cell per quotient bit.
   localparam int NUM_W     = CARRIER_W + FRAC_SHIFT;
   localparam int DIV_STEPS = NUM_W;

   // Exact floor(x / 3) for any x below 2^32: (x * 0xAAAAAAAB) >> 33.
   localparam int                RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP3     = 32'hAAAA_AAAB;
   localparam int                RECIP_SHIFT = 33;
   localparam int                PROD_W      = CRYSTAL_W + RECIP_W;

   localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 25'd30_000_000;
   localparam logic [INT_W-1:0]     INT_WORD_MAX  = 8'd255;
   // Largest quotient whose integer word (quotient minus one) still fits.
   localparam logic [CARRIER_W-1:0] QUO_LIMIT     = 31'd256;

   // Upper band bounds; the carrier lies below the bound.
   localparam logic [CARRIER_W-1:0] BOUND_DIV24 = 31'd177_000_000;
   localparam logic [CARRIER_W-1:0] BOUND_DIV16 = 31'd239_000_000;
   localparam logic [CARRIER_W-1:0] BOUND_DIV12 = 31'd353_000_000;
   localparam logic [CARRIER_W-1:0] BOUND_DIV8  = 31'd525_000_000;
   localparam logic [CARRIER_W-1:0] BOUND_DIV6  = 31'd705_000_000;

   typedef enum logic [BAND_W-1:0] {
      BAND_DIV4  = 3'd0,
      BAND_DIV6  = 3'd1,
      BAND_DIV8  = 3'd2,
      BAND_DIV12 = 3'd3,
      BAND_DIV16 = 3'd4,
      BAND_DIV24 = 3'd5
   } band_type;

   // Payload carried down the divider chain.
   typedef struct packed {
      logic [PFD_W-1:0] rem;   // partial remainder
      logic [NUM_W-1:0] nq;    // dividend bits still to come, quotient bits below
      logic [PFD_W-1:0] pfd;   // divisor
      band_type         band;
   } cell_type;

   // One finished result beat.
   typedef struct packed {
      band_type          band;
      logic [DIV_W-1:0]  divider;
      logic [INT_W-1:0]  int_word;
      logic [FRAC_W-1:0] frac_word;
      logic              range_err;
   } result_type;

   // Band selection from the carrier frequency.
   function automatic band_type band_of(input logic [CARRIER_W-1:0] carrier);
      band_type band;
      if (carrier < BOUND_DIV24) begin
         band = BAND_DIV24;
      end else if (carrier < BOUND_DIV16) begin
         band = BAND_DIV16;
      end else if (carrier < BOUND_DIV12) begin
         band = BAND_DIV12;
      end else if (carrier < BOUND_DIV8) begin
         band = BAND_DIV8;
      end else if (carrier < BOUND_DIV6) begin
         band = BAND_DIV6;
      end else begin
         band = BAND_DIV4;
      end
      return band;
   endfunction

   // Output divider belonging to a band.
   function automatic logic [DIV_W-1:0] divider_of(input band_type band);
      logic [DIV_W-1:0] divider;
      case (band)
         BAND_DIV4:  divider = 5'd4;
         BAND_DIV6:  divider = 5'd6;
         BAND_DIV8:  divider = 5'd8;
         BAND_DIV12: divider = 5'd12;
         BAND_DIV16: divider = 5'd16;
         BAND_DIV24: divider = 5'd24;
         default:    divider = 5'd4;
      endcase
      return divider;
   endfunction

endpackage

@@ src/fractional_pll_divider_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation: top level
// Turns a carrier frequency into band, output divider, integer word and
// fraction word by an exact 50-bit by 24-bit division in a chain of cells.
//
//   Channel  Direction  Handshake          Beat contents
//   req      in         valid / ready      carrier_hz
//   rsp      out        valid / ready      band, divider, integer, fraction, error
//   csr      in         write enable only  crystal_hz
//
// One beat is accepted per cycle while the result queue has room. A result
// is offered once it has passed two front-end stages, fifty one-bit divider
// cells and the queue, the first stage loading at the accepting edge. The
// whole pipeline holds while the two-entry result queue is full. Reset is
// synchronous and sets the crystal to 30 MHz and empties the pipe.
// ----------------------------------------------------------------------------
module fractional_pll_divider_calc (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fpdc_pkg::CARRIER_W-1:0]     req_carrier_hz,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fpdc_pkg::BAND_W-1:0]        rsp_band_code,
   output logic [fpdc_pkg::DIV_W-1:0]         rsp_output_divider,
   output logic [fpdc_pkg::INT_W-1:0]         rsp_integer_word,
   output logic [fpdc_pkg::FRAC_W-1:0]        rsp_fraction_word,
   output logic                               rsp_range_error,
   input  logic                               csr_wr_en,
   input  logic [fpdc_pkg::CRYSTAL_W-1:0]     csr_wr_data
);
   import fpdc_pkg::*;

   logic [CRYSTAL_W-1:0] crystal_ff;
   logic                 en;
   logic                 full;
   logic                 push;
   logic                 cell_valid [0:DIV_STEPS];
   cell_type             cell_data  [0:DIV_STEPS];
   cell_type             last;
   logic [CARRIER_W-1:0] quotient;
   result_type           result;
   result_type           rsp_data;

   // Crystal frequency register.
   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff <= CRYSTAL_RESET;
      end else if (csr_wr_en) begin
         crystal_ff <= csr_wr_data;
      end
   end

   // The pipe advances whenever the result queue has room.
   assign en        = ~full;
   assign req_ready = en;

   fpdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .carrier   (req_carrier_hz),
      .crystal   (crystal_ff),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0])
   );

   // One cell per quotient bit.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      fpdc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_valid[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   // The full quotient is floor(carrier * 2^19 / pfd); its top bits give
   // floor(carrier / pfd). If pfd > 0 the fraction is low 19 bits plus the one.
   assign last     = cell_data[DIV_STEPS];
   assign quotient = last.nq[NUM_W-1 -: CARRIER_W];

   always_comb begin
      result.band      = last.band;
      result.divider   = divider_of(last.band);
      result.frac_word = {1'b1, last.nq[FRAC_SHIFT-1:0]};
      result.int_word  = INT_W'(quotient - 31'd1);
      result.range_err = 1'b0;
      if (last.pfd == '0) begin
         // Crystal too slow for a usable phase detector frequency.
         result.int_word  = INT_WORD_MAX;
         result.frac_word = '0;
         result.range_err = 1'b1;
      end else if (quotient == '0) begin
         // Carrier below the phase detector frequency.
         result.int_word  = '0;
         result.range_err = 1'b1;
      end else if (quotient > QUO_LIMIT) begin
         result.int_word  = INT_WORD_MAX;
         result.range_err = 1'b1;
      end
   end

   assign push = cell_valid[DIV_STEPS] & en;

   fpdc_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop_ready (rsp_ready),
      .full      (full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_band_code      = rsp_data.band;
   assign rsp_output_divider = rsp_data.divider;
   assign rsp_integer_word   = rsp_data.int_word;
   assign rsp_fraction_word  = rsp_data.frac_word;
   assign rsp_range_error    = rsp_data.range_err;

   // Divider and band of a delivered beat belong together.
   a_band_divider: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_output_divider == divider_of(band_type'(rsp_band_code))))
      else $error("output divider does not match band code");

   // Without an error the fraction carries its leading one.
   a_frac_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_range_error) |-> rsp_fraction_word[FRAC_W-1])
      else $error("fraction word lost its leading one");

   // Requests are only held off while results are waiting.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready) || $past(rsp_valid))
      else $error("request refused with no result waiting");

endmodule

@@ src/fpdc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation: front end
// Registers the carrier with its band, then forms the phase detector
// frequency floor(2 * crystal / divider) and loads the first divider cell.
// ----------------------------------------------------------------------------
module fpdc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [fpdc_pkg::CARRIER_W-1:0]     carrier,
   input  logic [fpdc_pkg::CRYSTAL_W-1:0]     crystal,
   output logic                               out_valid,
   output fpdc_pkg::cell_type                 out_data
);
   import fpdc_pkg::*;

   logic                 s0_valid_ff;
   logic [CARRIER_W-1:0] s0_carrier_ff;
   band_type             s0_band_ff;
   band_type             s0_band_in;

   logic                 s1_valid_ff;
   cell_type             s1_data_ff;
   cell_type             s1_data_in;

   logic [PROD_W-1:0]    prod;
   logic [PFD_W-1:0]     third;
   logic [PFD_W-1:0]     pfd;

   // Band choice on the incoming beat.
   assign s0_band_in = band_of(carrier);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_carrier_ff <= carrier;
         s0_band_ff    <= s0_band_in;
         s1_data_ff    <= s1_data_in;
      end
   end

   // crystal / 3 by reciprocal multiplication; twice the crystal over 6, 12
   // or 24 is then this third shifted, over 4, 8 or 16 the crystal shifted.
   assign prod  = PROD_W'(crystal) * PROD_W'(RECIP3);
   assign third = prod[RECIP_SHIFT +: PFD_W];

   always_comb begin
      case (s0_band_ff)
         BAND_DIV4:  pfd = crystal[CRYSTAL_W-1:1];
         BAND_DIV6:  pfd = third;
         BAND_DIV8:  pfd = PFD_W'(crystal >> 2);
         BAND_DIV12: pfd = third >> 1;
         BAND_DIV16: pfd = PFD_W'(crystal >> 3);
         BAND_DIV24: pfd = third >> 2;
         default:    pfd = crystal[CRYSTAL_W-1:1];
      endcase
   end

   // Dividend is carrier * 2^19, remainder starts at zero.
   always_comb begin
      s1_data_in.rem  = '0;
      s1_data_in.nq   = {s0_carrier_ff, {FRAC_SHIFT{1'b0}}};
      s1_data_in.pfd  = pfd;
      s1_data_in.band = s0_band_ff;
   end

   assign out_valid = s1_valid_ff;
   assign out_data  = s1_data_ff;

endmodule

@@ src/fpdc_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation: divider cell
// One restoring division step: brings the next dividend bit into the partial
// remainder, subtracts the divisor where it fits and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module fpdc_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  fpdc_pkg::cell_type in_data,
   output logic               out_valid,
   output fpdc_pkg::cell_type out_data
);
   import fpdc_pkg::*;

   logic             valid_ff;
   cell_type         data_ff;
   cell_type         data_in;

   logic [PFD_W:0]   trial;
   logic [PFD_W:0]   diff;
   logic             fits;

   // Trial subtraction against the divisor.
   assign trial = {in_data.rem, in_data.nq[NUM_W-1]};
   assign diff  = trial - {1'b0, in_data.pfd};
   assign fits  = (trial >= {1'b0, in_data.pfd});

   always_comb begin
      data_in      = in_data;
      data_in.rem  = fits ? diff[PFD_W-1:0] : trial[PFD_W-1:0];
      data_in.nq   = {in_data.nq[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ src/fpdc_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation: result queue
// Two-entry queue between the divider chain and the result channel, so the
// chain keeps moving while a finished beat waits to be taken.
// ----------------------------------------------------------------------------
module fpdc_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fpdc_pkg::result_type push_data,
   input  logic                 pop_ready,
   output logic                 full,
   output logic                 out_valid,
   output fpdc_pkg::result_type out_data
);
   import fpdc_pkg::*;

   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic        pop;
   result_type  slot_ff [2];

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid & pop_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation: testbench
// Feeds carrier frequencies through the request channel under a series of
// crystal settings and compares every result beat with settings worked out
// here in exact integer arithmetic. The sender and the receiver idle and stall
// in several patterns, and the request side pauses at times until the block
// has drained.
// ----------------------------------------------------------------------------
module testbench;
   import fpdc_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned DRAIN_CYCLES  = 60;
   localparam int unsigned PHASE_ITEMS   = 95;
   localparam int unsigned MAX_PRINTED   = 40;
   localparam logic [CARRIER_W-1:0] CARRIER_MAX = '1;
   localparam logic [CRYSTAL_W-1:0] CRYSTAL_MAX = '1;

   // Expected synthesizer settings together with what produced them.
   typedef struct {
      logic [CARRIER_W-1:0] carrier;
      logic [CRYSTAL_W-1:0] crystal;
      result_type           want;
   } pll_expectation_type;

   // Holds the crystal setting and the settings still awaited from the block.
   class pll_settings_board_type;
      logic [CRYSTAL_W-1:0] crystal;
      pll_expectation_type  awaited_settings[$];
      int unsigned          errors;
      int unsigned          checked;
      int unsigned          flagged;

      function new();
         crystal = CRYSTAL_RESET;
         errors  = 0;
         checked = 0;
         flagged = 0;
      endfunction

      // Phase detector frequency for one output divider.
      function longint unsigned pfd_for(int unsigned divider);
         longint unsigned xtal;
         xtal = crystal;
         return (2 * xtal) / divider;
      endfunction

      // Band, divider, integer and fraction words for one carrier.
      function result_type synth_settings(logic [CARRIER_W-1:0] carrier);
         result_type      r;
         longint unsigned f, pfd, quo, quo_scaled, n, frac;
         f = carrier;
         if (carrier < BOUND_DIV24) begin
            r.band = BAND_DIV24;
            r.divider = 5'd24;
         end else if (carrier < BOUND_DIV16) begin
            r.band = BAND_DIV16;
            r.divider = 5'd16;
         end else if (carrier < BOUND_DIV12) begin
            r.band = BAND_DIV12;
            r.divider = 5'd12;
         end else if (carrier < BOUND_DIV8) begin
            r.band = BAND_DIV8;
            r.divider = 5'd8;
         end else if (carrier < BOUND_DIV6) begin
            r.band = BAND_DIV6;
            r.divider = 5'd6;
         end else begin
            r.band = BAND_DIV4;
            r.divider = 5'd4;
         end
         pfd = pfd_for(r.divider);
         if (pfd == 0) begin
            // A crystal too slow for the divider leaves nothing to divide by.
            r.int_word  = INT_WORD_MAX;
            r.frac_word = '0;
            r.range_err = 1'b1;
         end else begin
            quo        = f / pfd;
            quo_scaled = (f << FRAC_SHIFT) / pfd;
            if (quo == 0) begin
               // Carrier below the phase detector frequency: N is minus one.
               r.int_word  = '0;
               r.range_err = 1'b1;
               frac        = quo_scaled + (64'd1 << FRAC_SHIFT);
            end else begin
               n    = quo - 1;
               frac = quo_scaled - (n << FRAC_SHIFT);
               if (n > INT_WORD_MAX) begin
                  r.int_word  = INT_WORD_MAX;
                  r.range_err = 1'b1;
               end else begin
                  r.int_word  = n[INT_W-1:0];
                  r.range_err = 1'b0;
               end
            end
            r.frac_word = frac[FRAC_W-1:0];
         end
         return r;
      endfunction

      function void note_request(logic [CARRIER_W-1:0] carrier);
         pll_expectation_type e;
         e.carrier = carrier;
         e.crystal = crystal;
         e.want    = synth_settings(carrier);
         awaited_settings.push_back(e);
      endfunction

      task report(string what);
         errors++;
         // Past a few dozen lines further mismatches are only counted.
         if (errors <= MAX_PRINTED) begin
            $display("tb: mismatch: %s", what);
         end
      endtask

      task check_result(result_type got);
         pll_expectation_type e;
         string               tag;
         if (awaited_settings.size() == 0) begin
            report($sformatf("result beat with nothing outstanding (band %0d)", got.band));
            return;
         end
         e = awaited_settings.pop_front();
         checked++;
         if (e.want.range_err) begin
            flagged++;
         end
         tag = $sformatf("carrier %0d crystal %0d:", e.carrier, e.crystal);
         if (got.band !== e.want.band) begin
            report($sformatf("%s band %0d, expected %0d", tag, got.band, e.want.band));
         end
         if (got.divider !== e.want.divider) begin
            report($sformatf("%s divider %0d, expected %0d", tag, got.divider,
                             e.want.divider));
         end
         if (got.int_word !== e.want.int_word) begin
            report($sformatf("%s integer word %0d, expected %0d", tag, got.int_word,
                             e.want.int_word));
         end
         if (got.frac_word !== e.want.frac_word) begin
            report($sformatf("%s fraction word 0x%05h, expected 0x%05h", tag,
                             got.frac_word, e.want.frac_word));
         end
         if (got.range_err !== e.want.range_err) begin
            report($sformatf("%s range error %0b, expected %0b", tag, got.range_err,
                             e.want.range_err));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CARRIER_W-1:0] req_carrier_hz = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BAND_W-1:0]    rsp_band_code;
   logic [DIV_W-1:0]     rsp_output_divider;
   logic [INT_W-1:0]     rsp_integer_word;
   logic [FRAC_W-1:0]    rsp_fraction_word;
   logic                 rsp_range_error;
   logic                 csr_wr_en = 1'b0;
   logic [CRYSTAL_W-1:0] csr_wr_data = '0;

   pll_settings_board_type settings_board;
   int unsigned            sender_idle_pct = 0;
   int unsigned            receiver_stall_pct = 0;
   int unsigned            cycle_count = 0;
   int unsigned            crystal_settings = 1;

   fractional_pll_divider_calc uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_carrier_hz     (req_carrier_hz),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_band_code      (rsp_band_code),
      .rsp_output_divider (rsp_output_divider),
      .rsp_integer_word   (rsp_integer_word),
      .rsp_fraction_word  (rsp_fraction_word),
      .rsp_range_error    (rsp_range_error),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: ready is withheld at random in the stalling phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Every result beat is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : rsp_monitor
      result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.band      = band_type'(rsp_band_code);
         seen.divider   = rsp_output_divider;
         seen.int_word  = rsp_integer_word;
         seen.frac_word = rsp_fraction_word;
         seen.range_err = rsp_range_error;
         settings_board.check_result(seen);
      end
   end

   // Offers one carrier beat, with random idle cycles ahead of it, and
   // returns at the edge at which it is taken.
   task send_carrier(input logic [CARRIER_W-1:0] carrier);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_carrier_hz <= carrier;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      settings_board.note_request(carrier);
   endtask

   // Holds the request side off until every outstanding result has arrived.
   task wait_drained();
      req_valid <= 1'b0;
      while (settings_board.awaited_settings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task write_crystal(input logic [CRYSTAL_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_board.crystal = value;
      crystal_settings++;
   endtask

   // Carriers drawn from a mix of ranges: the whole field, the useful band,
   // near each band bound, scattered over every magnitude, and close to
   // whole multiples of a phase detector frequency.
   function automatic logic [CARRIER_W-1:0] random_carrier();
      logic [31:0]     word;
      longint unsigned pfd, near;
      int unsigned     dividers[6] = '{4, 6, 8, 12, 16, 24};
      word = $urandom();
      case ($urandom_range(0, 4))
         0: begin
            word = $urandom();
         end
         1: begin
            word = $urandom_range(100_000_000, 1_100_000_000);
         end
         2: begin
            case ($urandom_range(0, 4))
               0: word = BOUND_DIV24;
               1: word = BOUND_DIV16;
               2: word = BOUND_DIV12;
               3: word = BOUND_DIV8;
               default: word = BOUND_DIV6;
            endcase
            word = word + $urandom_range(0, 6) - 3;
         end
         3: begin
            word = $urandom_range(0, (32'd1 << $urandom_range(1, 31)) - 1);
         end
         default: begin
            pfd = settings_board.pfd_for(dividers[$urandom_range(0, 5)]);
            if (pfd != 0) begin
               near = $urandom_range(1, 300) * pfd + $urandom_range(0, 2) - 1;
               word = near[31:0];
            end
         end
      endcase
      return word[CARRIER_W-1:0];
   endfunction

   initial begin
      logic [CARRIER_W-1:0] corners[$];
      logic [CRYSTAL_W-1:0] crystals[$];
      int unsigned          phase;
      settings_board = new();

      // Boundary carriers under the reset crystal of 30 MHz: zero, the
      // field maximum, both sides of every band bound, a carrier just below
      // and at the phase detector frequency, and exact multiples of it.
      corners = '{31'd0, 31'd1, 31'd2_499_999, 31'd2_500_000, 31'd7_500_000,
                  31'd100_000_000, 31'd176_999_999, 31'd177_000_000,
                  31'd238_999_999, 31'd239_000_000, 31'd352_999_999,
                  31'd353_000_000, 31'd524_999_999, 31'd525_000_000,
                  31'd704_999_999, 31'd705_000_000, 31'd1_100_000_000,
                  31'd1_500_000_000, CARRIER_MAX, 31'h5555_5555, 31'h2AAA_AAAA};

      // Crystal settings: the stated extremes, the field extremes, values
      // so small that the phase detector frequency vanishes or the integer
      // word saturates, random ones, and the reset value again at the end.
      crystals = '{25'd10_000_000, 25'd32_000_000, CRYSTAL_MAX, 25'd0, 25'd1,
                   25'd11, 25'd12, 25'd2, 25'd1_000_000, 25'd3_000_000,
                   25'd26_000_000};
      crystals.push_back(CRYSTAL_W'($urandom_range(0, CRYSTAL_MAX)));
      crystals.push_back(CRYSTAL_W'($urandom_range(10_000_000, 32_000_000)));
      crystals.push_back(CRYSTAL_W'($urandom_range(1, 4_000_000)));
      crystals.push_back(CRYSTAL_RESET);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (corners[i]) begin
         send_carrier(corners[i]);
      end
      wait_drained();

      // One phase per crystal setting, each with one of four idling patterns in
      // turn and a full drain half-way through.
      phase = 0;
      foreach (crystals[c]) begin
         write_crystal(crystals[c]);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 46;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 46;
            end
            default: begin
               sender_idle_pct    = 7;
               receiver_stall_pct = 7;
            end
         endcase
         for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
            send_carrier(random_carrier());
            if (i == PHASE_ITEMS / 2) begin
               wait_drained();
            end
         end
         wait_drained();
         phase++;
      end

      // Allow for any stray beat still in the pipeline.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (settings_board.awaited_settings.size() != 0) begin
         settings_board.report($sformatf("%0d results never arrived",
                                         settings_board.awaited_settings.size()));
      end

      $display("tb: %0d carrier beats checked across %0d crystal settings",
               settings_board.checked, crystal_settings);
      $display("tb: %0d of them flagged out of range, %0d mismatches",
               settings_board.flagged, settings_board.errors);
      if (settings_board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
